FILE: rtl/surplus_heater_hysteresis_control_top_assert.svh
// ----------------------------------------------------------------------------
// surplus heater control assertion macros
// Concurrent checks sampled on clk, optionally gated off during rst.
// ----------------------------------------------------------------------------
`ifndef SURPLUS_HEATER_HYSTERESIS_CONTROL_TOP_ASSERT_SVH
`define SURPLUS_HEATER_HYSTERESIS_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every edge outside reset
`define SHHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define SHHC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SHHC_ASSERT(label, prop, msg)

`define SHHC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/shhc_pkg.sv
// ----------------------------------------------------------------------------
// shhc_pkg
// Types and constants of the surplus heater hysteresis controller.
// ----------------------------------------------------------------------------
package shhc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_HEAT_LIMIT    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ON_THRESHOLD  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_OFF_THRESHOLD = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ON_DELAY      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_OFF_DELAY     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_STALE_LIMIT   = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_OUTPUT_ENABLE = 3'd6;

  // register reset values
  localparam logic        [10:0] HEAT_LIMIT_RESET    = 11'd700;
  localparam logic signed [15:0] ON_THRESHOLD_RESET  = -16'sd1200;
  localparam logic signed [15:0] OFF_THRESHOLD_RESET = -16'sd100;
  localparam logic        [15:0] ON_DELAY_RESET      = 16'd30;
  localparam logic        [15:0] OFF_DELAY_RESET     = 16'd60;
  localparam logic        [15:0] STALE_LIMIT_RESET   = 16'd300;
  localparam logic               OUTPUT_ENABLE_RESET = 1'b1;

  typedef struct packed {
    logic signed [15:0] power_w;
    logic signed [11:0] tank_reading;
    logic        [31:0] temp_seen_at;
    logic        [31:0] now_sec;
  } in_item_t;

  typedef struct packed {
    logic heater_on;
    logic reading_old;
    logic over_cap;
  } out_item_t;

endpackage

FILE: rtl/surplus_heater_hysteresis_control_top.sv
// ----------------------------------------------------------------------------
// surplus_heater_hysteresis_control_top
// Hysteresis and delay based on/off control of a surplus-power tank heater.
// ----------------------------------------------------------------------------
// One poll sample goes in per transaction and one status result comes out.
// The block takes one sample every clock cycle while the output side does not
// stall; a result passes through the input register and then the result
// register, and is held there while the output side stalls. The sustained rate
// of one sample per cycle is set by the heater and timer registers, whose
// update for a sample is one pass of compares and 33-bit time differences.
// Configuration writes are always ready and should be issued only while no
// sample is in flight.
`include "surplus_heater_hysteresis_control_top_assert.svh"

module surplus_heater_hysteresis_control_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  shhc_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output shhc_pkg::out_item_t                     out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [shhc_pkg::CfgIndexWidth-1:0]      cfg_index,
  input  logic [shhc_pkg::CfgDataWidth-1:0]       cfg_data
);
  import shhc_pkg::*;

  // configuration
  logic        [10:0] heat_limit;
  logic signed [15:0] on_threshold;
  logic signed [15:0] off_threshold;
  logic        [15:0] on_delay;
  logic        [15:0] off_delay;
  logic        [15:0] stale_limit;
  logic               output_enable;

  // control state
  logic        heater_state, heater_state_next;
  logic        on_timing, on_timing_next;
  logic        off_timing, off_timing_next;
  logic [31:0] on_timer_start, on_timer_start_next;
  logic [31:0] off_timer_start, off_timer_start_next;

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_advance;
  logic     s1_fire;

  // datapath
  logic signed [32:0] age;
  logic signed [32:0] on_elapsed;
  logic signed [32:0] off_elapsed;
  logic [31:0]        on_start_eff;
  logic [31:0]        off_start_eff;
  logic               stale;
  logic               over;
  out_item_t          result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heat_limit    <= HEAT_LIMIT_RESET;
      on_threshold  <= ON_THRESHOLD_RESET;
      off_threshold <= OFF_THRESHOLD_RESET;
      on_delay      <= ON_DELAY_RESET;
      off_delay     <= OFF_DELAY_RESET;
      stale_limit   <= STALE_LIMIT_RESET;
      output_enable <= OUTPUT_ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAT_LIMIT:    heat_limit    <= cfg_data[10:0];
        REG_ON_THRESHOLD:  on_threshold  <= $signed(cfg_data);
        REG_OFF_THRESHOLD: off_threshold <= $signed(cfg_data);
        REG_ON_DELAY:      on_delay      <= cfg_data;
        REG_OFF_DELAY:     off_delay     <= cfg_data;
        REG_STALE_LIMIT:   stale_limit   <= cfg_data;
        REG_OUTPUT_ENABLE: output_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the result register is free or draining
  assign s1_advance = !out_valid || !out_stall;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  // time differences are exact signed 33-bit values
  assign on_start_eff  = on_timing  ? on_timer_start  : s1_item.now_sec;
  assign off_start_eff = off_timing ? off_timer_start : s1_item.now_sec;
  assign age         = $signed({1'b0, s1_item.now_sec}) - $signed({1'b0, s1_item.temp_seen_at});
  assign on_elapsed  = $signed({1'b0, s1_item.now_sec}) - $signed({1'b0, on_start_eff});
  assign off_elapsed = $signed({1'b0, s1_item.now_sec}) - $signed({1'b0, off_start_eff});

  assign stale = (s1_item.temp_seen_at == 32'd0) ||
                 (age >= $signed({17'd0, stale_limit}));
  assign over  = !stale && (s1_item.tank_reading >= $signed({1'b0, heat_limit}));

  always_comb begin
    heater_state_next    = heater_state;
    on_timing_next       = on_timing;
    on_timer_start_next  = on_timer_start;
    off_timing_next      = off_timing;
    off_timer_start_next = off_timer_start;
    if (stale || over) begin
      if (output_enable) begin
        heater_state_next = 1'b0;
      end
      on_timing_next       = 1'b0;
      on_timer_start_next  = 32'd0;
      off_timing_next      = 1'b0;
      off_timer_start_next = 32'd0;
    end else if (!heater_state) begin
      if (output_enable) begin
        if (s1_item.power_w < on_threshold) begin
          on_timing_next      = 1'b1;
          on_timer_start_next = on_start_eff;
          if (on_elapsed >= $signed({17'd0, on_delay})) begin
            heater_state_next    = 1'b1;
            on_timing_next       = 1'b0;
            on_timer_start_next  = 32'd0;
            off_timing_next      = 1'b0;
            off_timer_start_next = 32'd0;
          end
        end else begin
          on_timing_next      = 1'b0;
          on_timer_start_next = 32'd0;
        end
      end
    end else begin
      if (s1_item.power_w > off_threshold) begin
        off_timing_next      = 1'b1;
        off_timer_start_next = off_start_eff;
        if (off_elapsed >= $signed({17'd0, off_delay})) begin
          // with the output disabled the request is dropped, timers still clear
          if (output_enable) begin
            heater_state_next = 1'b0;
          end
          on_timing_next       = 1'b0;
          on_timer_start_next  = 32'd0;
          off_timing_next      = 1'b0;
          off_timer_start_next = 32'd0;
        end
      end else begin
        off_timing_next      = 1'b0;
        off_timer_start_next = 32'd0;
      end
    end
  end

  always_comb begin
    result.heater_on   = heater_state_next;
    result.reading_old = stale;
    result.over_cap    = over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_state    <= 1'b0;
      on_timing       <= 1'b0;
      on_timer_start  <= 32'd0;
      off_timing      <= 1'b0;
      off_timer_start <= 32'd0;
    end else if (s1_fire) begin
      heater_state    <= heater_state_next;
      on_timing       <= on_timing_next;
      on_timer_start  <= on_timer_start_next;
      off_timing      <= off_timing_next;
      off_timer_start <= off_timer_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // a stale reading never reports an over-temperature
  `SHHC_ASSERT(a_stale_not_over,
    out_valid |-> !(out_data.reading_old && out_data.over_cap),
    "stale result flagged over cap")
  // turn-on timing only runs with the heater off, turn-off timing only with it on
  `SHHC_ASSERT(a_timer_matches_heater,
    !(on_timing && heater_state) && !(off_timing && !heater_state),
    "timer running in wrong heater state")
  // the heater only switches on from a processed sample with the output enabled
  `SHHC_ASSERT(a_heater_on_cause,
    $rose(heater_state) |-> $past(s1_fire && output_enable),
    "heater switched on without an enabled sample")
  // the controller state moves only when a sample passes to the result register
  `SHHC_ASSERT(a_state_hold,
    !$past(s1_fire) |-> $stable(heater_state) && $stable(on_timing) && $stable(off_timing),
    "control state changed without a sample")

endmodule

FILE: dv/surplus_heater_hysteresis_control_top_test.sv
// ----------------------------------------------------------------------------
// surplus heater hysteresis control testbench
// Sends poll samples through the block under several register settings, with
// random idling on both channels, and checks every status result against a
// cycle-free prediction of the heater and timer state.
// ----------------------------------------------------------------------------
module surplus_heater_hysteresis_control_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import shhc_pkg::*;

  class heater_state_tracker;
    logic        [10:0] heat_limit;
    logic signed [15:0] on_thr;
    logic signed [15:0] off_thr;
    logic        [15:0] on_delay;
    logic        [15:0] off_delay;
    logic        [15:0] stale_limit;
    logic               out_en;

    logic        heater;
    logic        on_run;
    logic [31:0] on_start;
    logic        off_run;
    logic [31:0] off_start;

    out_item_t status_due[$];
    int        mismatches;

    function new();
      heat_limit  = HEAT_LIMIT_RESET;
      on_thr      = ON_THRESHOLD_RESET;
      off_thr     = OFF_THRESHOLD_RESET;
      on_delay    = ON_DELAY_RESET;
      off_delay   = OFF_DELAY_RESET;
      stale_limit = STALE_LIMIT_RESET;
      out_en      = OUTPUT_ENABLE_RESET;
      heater      = 1'b0;
      mismatches  = 0;
      clear_timers();
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_HEAT_LIMIT:    heat_limit  = data[10:0];
        REG_ON_THRESHOLD:  on_thr      = data;
        REG_OFF_THRESHOLD: off_thr     = data;
        REG_ON_DELAY:      on_delay    = data;
        REG_OFF_DELAY:     off_delay   = data;
        REG_STALE_LIMIT:   stale_limit = data;
        REG_OUTPUT_ENABLE: out_en      = data[0];
        default: ;
      endcase
    endfunction

    function void clear_timers();
      on_run    = 1'b0;
      on_start  = '0;
      off_run   = 1'b0;
      off_start = '0;
    endfunction

    // switch requests only take effect while the output is available
    function void request(logic want);
      if (out_en) begin
        heater = want;
      end
    endfunction

    // exact signed difference of two second counts
    function longint span(logic [31:0] later, logic [31:0] earlier);
      return longint'({32'd0, later}) - longint'({32'd0, earlier});
    endfunction

    function void take_sample(in_item_t s);
      out_item_t r;
      logic      stale;
      r = '0;
      stale = (s.temp_seen_at == '0) ||
              (span(s.now_sec, s.temp_seen_at) >= longint'(stale_limit));
      if (stale) begin
        request(1'b0);
        clear_timers();
      end else if ($signed(s.tank_reading) >= $signed({1'b0, heat_limit})) begin
        r.over_cap = 1'b1;
        request(1'b0);
        clear_timers();
      end else if (!heater) begin
        if (out_en) begin
          if ($signed(s.power_w) < on_thr) begin
            if (!on_run) begin
              on_run   = 1'b1;
              on_start = s.now_sec;
            end
            if (span(s.now_sec, on_start) >= longint'(on_delay)) begin
              request(1'b1);
              clear_timers();
            end
          end else begin
            on_run   = 1'b0;
            on_start = '0;
          end
        end
      end else begin
        if ($signed(s.power_w) > off_thr) begin
          if (!off_run) begin
            off_run   = 1'b1;
            off_start = s.now_sec;
          end
          if (span(s.now_sec, off_start) >= longint'(off_delay)) begin
            request(1'b0);
            clear_timers();
          end
        end else begin
          off_run   = 1'b0;
          off_start = '0;
        end
      end
      r.heater_on   = heater;
      r.reading_old = stale;
      status_due.push_back(r);
    endfunction

    function void match_status(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: status %b arrived with no sample waiting", got);
        end
        return;
      end
      want = status_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"mismatch at %0t: heater_on exp %b got %b, reading_old exp %b got %b,",
                    " over_cap exp %b got %b"},
                   $realtime, want.heater_on, got.heater_on, want.reading_old,
                   got.reading_old, want.over_cap, got.over_cap);
        end
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  logic        steady = 1'b0;
  logic [31:0] wall_s = 32'd1000;
  logic [31:0] read_s = 32'd1000;

  heater_state_tracker tracker = new();

  surplus_heater_hysteresis_control_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL surplus_heater_hysteresis_control_top");
    $finish;
  end

  // status side: random stall, check every accepted transaction
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 36);
    if (!rst && out_valid && !out_stall) begin
      tracker.match_status(out_data);
    end
  end

  function automatic in_item_t poll(int p, int t, logic [31:0] seen, logic [31:0] now);
    in_item_t s;
    s.power_w      = 16'(p);
    s.tank_reading = 12'(t);
    s.temp_seen_at = seen;
    s.now_sec      = now;
    return s;
  endfunction

  task automatic send_sample(in_item_t s);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(s);
  endtask

  // registers change only once every status has come back
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, int value);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, 16'(value));
    cfg_valid <= 1'b0;
  endtask

  function automatic int clip16(int p);
    if (p < -32768) return -32768;
    if (p > 32767) return 32767;
    return p;
  endfunction

  function automatic in_item_t next_sample();
    in_item_t s;
    int       kind;
    int       p;
    int       t;
    int       step_max;
    int       age_max;
    kind     = $urandom_range(0, 99);
    step_max = (int'(tracker.on_delay) + int'(tracker.off_delay)) / 8 + 3;
    age_max  = int'(tracker.stale_limit) / 2;
    if (kind >= 94) begin
      s.power_w      = 16'($urandom);
      s.tank_reading = 12'(int'($urandom_range(0, 1900)) - 400);
      s.temp_seen_at = $urandom;
      s.now_sec      = $urandom;
      return s;
    end
    // clock running backwards now and then
    if (kind < 7) begin
      wall_s = wall_s - $urandom_range(1, step_max);
    end else begin
      wall_s = wall_s + $urandom_range(0, step_max);
    end
    if (kind >= 80 && kind < 88) begin
      if ($urandom_range(0, 1) == 0) begin
        read_s = '0;
      end else begin
        read_s = wall_s - tracker.stale_limit - $urandom_range(0, 20);
      end
    end else if (kind >= 88) begin
      read_s = wall_s + $urandom_range(1, 50);
    end else if ($urandom_range(0, 3) != 0) begin
      read_s = wall_s - $urandom_range(0, age_max);
    end
    case ($urandom_range(0, 6))
      0, 1:    p = int'(tracker.on_thr) - int'($urandom_range(1, 500));
      2, 3:    p = int'(tracker.off_thr) + int'($urandom_range(1, 500));
      4:       p = int'(tracker.on_thr);
      5:       p = int'(tracker.off_thr);
      default: p = int'($signed(16'($urandom)));
    endcase
    if (tracker.heat_limit == '0 || $urandom_range(0, 6) == 0) begin
      t = int'($urandom_range(0, 1900)) - 400;
    end else begin
      t = int'($urandom_range(0, int'(tracker.heat_limit) + 399)) - 400;
    end
    return poll(clip16(p), t, read_s, wall_s);
  endfunction

  task automatic run_setting(int cap, int on_t, int off_t, int on_d, int off_d,
                             int stale_lim, int en, int count);
    write_reg(REG_HEAT_LIMIT, cap);
    write_reg(REG_ON_THRESHOLD, on_t);
    write_reg(REG_OFF_THRESHOLD, off_t);
    write_reg(REG_ON_DELAY, on_d);
    write_reg(REG_OFF_DELAY, off_d);
    write_reg(REG_STALE_LIMIT, stale_lim);
    write_reg(REG_OUTPUT_ENABLE, en);
    if ($urandom_range(0, 3) == 0) begin
      wall_s = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    end else begin
      wall_s = $urandom_range(1000, 100000);
    end
    read_s = wall_s;
    repeat (count) send_sample(next_sample());
    in_valid <= 1'b0;
  endtask

  task automatic run_random_setting(int count);
    int on_t;
    on_t = int'($urandom_range(0, 3000)) - 3000;
    run_setting($urandom_range(0, 1500), on_t, clip16(on_t + int'($urandom_range(0, 2500))),
                $urandom_range(0, 120), $urandom_range(0, 120), $urandom_range(20, 600),
                $urandom_range(0, 9) != 0, count);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stale, future reading, timer from second zero, backwards time
    send_sample(poll(-32768, 200, 32'd0, 32'd100));
    send_sample(poll(-2000, 200, 32'd5, 32'd0));
    send_sample(poll(-2000, 200, 32'd5, 32'd10));
    send_sample(poll(-2000, 200, 32'd5, 32'd5));
    send_sample(poll(-2000, 200, 32'd20, 32'd30));
    send_sample(poll(32767, 200, 32'd35, 32'd40));
    send_sample(poll(-100, 200, 32'd45, 32'd50));
    send_sample(poll(0, 200, 32'd55, 32'd60));
    send_sample(poll(0, -400, 32'd100, 32'd120));
    send_sample(poll(-2000, 700, 32'd125, 32'd130));
    send_sample(poll(-32768, 1500, 32'd125, 32'd131));
    send_sample(poll(-2000, 699, 32'd130, 32'd430));
    send_sample(poll(-2000, 699, 32'd131, 32'd430));
    send_sample(poll(-2000, 100, 32'hFFFF_FFFF, 32'h0000_0010));
    send_sample(poll(-2000, 100, 32'hFFFF_FF00, 32'hFFFF_FFFF));
    in_valid <= 1'b0;

    // zero delays, then output disabled while on and while off
    write_reg(REG_ON_DELAY, 0);
    write_reg(REG_OFF_DELAY, 0);
    send_sample(poll(-2000, 100, 32'd900, 32'd1000));
    in_valid <= 1'b0;
    write_reg(REG_OUTPUT_ENABLE, 0);
    send_sample(poll(500, 100, 32'd990, 32'd1001));
    send_sample(poll(500, 100, 32'd0, 32'd1002));
    in_valid <= 1'b0;
    write_reg(REG_OUTPUT_ENABLE, 1);
    send_sample(poll(500, 100, 32'd995, 32'd1003));
    in_valid <= 1'b0;
    write_reg(REG_OUTPUT_ENABLE, 0);
    send_sample(poll(-5000, 100, 32'd995, 32'd1004));
    send_sample(poll(-5000, 100, 32'd995, 32'd1005));
    in_valid <= 1'b0;

    run_setting(HEAT_LIMIT_RESET, ON_THRESHOLD_RESET, OFF_THRESHOLD_RESET, ON_DELAY_RESET,
                OFF_DELAY_RESET, STALE_LIMIT_RESET, OUTPUT_ENABLE_RESET, 100);
    run_setting(1500, 32767, -32768, 0, 0, 65535, 1, 100);
    run_setting(0, -32768, 32767, 65535, 65535, 0, 0, 60);
    steady = 1'b1;
    run_random_setting(120);
    steady = 1'b0;
    run_random_setting(110);
    run_random_setting(110);
    run_random_setting(100);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS surplus_heater_hysteresis_control_top");
    end else begin
      $display("FAIL surplus_heater_hysteresis_control_top");
    end
    $finish;
  end

endmodule
